// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/i2cs_pkg.sv =====
`default_nettype none

package i2cs_pkg;

	// default write buffer depth
	localparam int WRITE_DEPTH_DEF = 32;

	// item kinds on the command channel
	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_START = 2'd1,
		KIND_EVENT = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// one result item
	typedef struct packed {
		logic       dr_valid;
		logic [7:0] dr_value;
		logic       start_req;
		logic       stop_req;
		logic       ack_on;
		logic       buf_irq_on;
		logic       rd_valid;
		logic [7:0] rd_byte;
		logic [7:0] rd_count;
		logic       done_res;
		logic       failed;
		logic [6:0] error_bits;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/i2cs_ifs.sv =====
`default_nettype none

// Command channel: loads, starts, controller events, error events
interface i2cs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] wr_byte;
	logic [6:0] slave_addr;
	logic [5:0] write_len;
	logic [7:0] read_len;
	logic       start_sent;
	logic       addr_done;
	logic       transmitter;
	logic       tx_empty;
	logic       rx_full;
	logic [7:0] rx_byte;
	logic [6:0] error_in;

	modport source (
		output valid, kind, wr_byte, slave_addr, write_len, read_len,
		output start_sent, addr_done, transmitter, tx_empty, rx_full, rx_byte, error_in,
		input  ready
	);
	modport sink (
		input  valid, kind, wr_byte, slave_addr, write_len, read_len,
		input  start_sent, addr_done, transmitter, tx_empty, rx_full, rx_byte, error_in,
		output ready
	);
endinterface

// Result channel: controller actions and transfer status
interface i2cs_out_if;
	logic       valid;
	logic       ready;
	logic       dr_valid;
	logic [7:0] dr_value;
	logic       start_req;
	logic       stop_req;
	logic       ack_on;
	logic       buf_irq_on;
	logic       rd_valid;
	logic [7:0] rd_byte;
	logic [7:0] rd_count;
	logic       done_res;
	logic       failed;
	logic [6:0] error_bits;

	modport source (
		output valid, dr_valid, dr_value, start_req, stop_req, ack_on, buf_irq_on,
		output rd_valid, rd_byte, rd_count, done_res, failed, error_bits,
		input  ready
	);
	modport sink (
		input  valid, dr_valid, dr_value, start_req, stop_req, ack_on, buf_irq_on,
		input  rd_valid, rd_byte, rd_count, done_res, failed, error_bits,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/i2c_master_transfer_sequencer.sv =====
// Channel | Dir | Handshake   | Carries
// cmd     | in  | valid/ready | load, start, controller event, error event
// res     | out | valid/ready | data register write, START/STOP, ACK, status
//
// One result per command item; an item is taken every cycle when the result
// register is empty or being drained in that cycle. The result is registered.
// The next buffer byte is prefetched from the write buffer read port, so a
// transmit-empty event sees its byte with no wait.
// Reset (arst_n low) clears all control state; buffer contents are kept.
// A stall on res holds the result and backpressures cmd.
`default_nettype none

`include "assert_macros.svh"

module i2c_master_transfer_sequencer #(
	parameter int WRITE_DEPTH = i2cs_pkg::WRITE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	i2cs_in_if.sink    cmd,
	i2cs_out_if.source res
);

	localparam int CW = $clog2(WRITE_DEPTH + 1);
	localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
	localparam int LW = (CW > 6) ? CW : 6;
	localparam logic [LW-1:0] DEPTH_L = LW'(WRITE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(WRITE_DEPTH);

	// transfer state
	logic [CW-1:0] ld_ptr_q, ld_ptr_d;
	logic [CW-1:0] wr_idx_q, wr_idx_d;
	logic [CW-1:0] wr_tot_q, wr_tot_d;
	logic [7:0]    rd_idx_q, rd_idx_d;
	logic [7:0]    rd_tot_q, rd_tot_d;
	logic [6:0]    addr_q, addr_d;
	logic          ack_q, ack_d;
	logic          irq_q, irq_d;
	logic [6:0]    err_q, err_d;

	// result register
	logic              out_valid_q;
	i2cs_pkg::res_t    res_q, res_d;

	logic          in_fire;
	logic          buf_we;
	logic [7:0]    buf_rdata;
	logic          wr_more;
	logic [LW-1:0] wlen;
	logic [8:0]    rd_next_w;

	assign cmd.ready = !out_valid_q || res.ready;
	assign in_fire   = cmd.valid && cmd.ready;

	i2cs_wbuf #(
		.WRITE_DEPTH (WRITE_DEPTH),
		.AW          (AW)
	) u_wbuf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (ld_ptr_q[AW-1:0]),
		.wdata (cmd.wr_byte),
		.raddr (in_fire ? wr_idx_d[AW-1:0] : wr_idx_q[AW-1:0]),
		.rdata (buf_rdata)
	);

	// per-item sequencing; flags handled in controller order
	always_comb begin
		ld_ptr_d  = ld_ptr_q;
		wr_idx_d  = wr_idx_q;
		wr_tot_d  = wr_tot_q;
		rd_idx_d  = rd_idx_q;
		rd_tot_d  = rd_tot_q;
		addr_d    = addr_q;
		ack_d     = ack_q;
		irq_d     = irq_q;
		err_d     = err_q;
		buf_we    = 1'b0;
		res_d     = '0;
		wr_more   = wr_idx_q < wr_tot_q;
		wlen      = LW'(cmd.write_len);
		rd_next_w = '0;

		unique case (i2cs_pkg::kind_t'(cmd.kind))
			i2cs_pkg::KIND_LOAD: begin
				if (ld_ptr_q < DEPTH_C) begin
					buf_we   = in_fire;
					ld_ptr_d = ld_ptr_q + CW'(1);
				end
			end
			i2cs_pkg::KIND_START: begin
				addr_d    = cmd.slave_addr;
				wr_tot_d  = (wlen > DEPTH_L) ? DEPTH_C : CW'(wlen);
				rd_tot_d  = cmd.read_len;
				ld_ptr_d  = '0;
				wr_idx_d  = '0;
				rd_idx_d  = '0;
				err_d     = '0;
				irq_d     = 1'b1;
				res_d.start_req = 1'b1;
			end
			i2cs_pkg::KIND_EVENT: begin
				// address phase: direction bit is read once writes are used up
				if (cmd.start_sent) begin
					res_d.dr_valid = 1'b1;
					res_d.dr_value = {addr_q, !wr_more};
				end
				// address acked in receiver mode
				if (cmd.addr_done && !cmd.transmitter) begin
					irq_d = 1'b1;
					if (rd_tot_q > 8'd1) begin
						ack_d = 1'b1;
					end else begin
						ack_d = 1'b0;
						res_d.stop_req = 1'b1;
					end
				end
				// transmit side: next byte, or turn around / finish
				if (cmd.tx_empty) begin
					if (wr_more) begin
						res_d.dr_valid = 1'b1;
						res_d.dr_value = buf_rdata;
						wr_idx_d = wr_idx_q + CW'(1);
					end else begin
						irq_d = 1'b0;
						if (rd_tot_q != 8'd0) begin
							res_d.start_req = 1'b1;
						end else begin
							res_d.stop_req = 1'b1;
							res_d.done_res = 1'b1;
						end
					end
				end
				// receive side: deliver byte, NACK before the last one
				if (cmd.rx_full) begin
					res_d.rd_valid = 1'b1;
					res_d.rd_byte  = cmd.rx_byte;
					if (rd_idx_q != 8'hFF) begin
						rd_idx_d = rd_idx_q + 8'd1;
					end
					rd_next_w = {1'b0, rd_idx_d};
					if ((rd_next_w + 9'd2) > {1'b0, rd_tot_q}) begin
						ack_d = 1'b0;
						res_d.stop_req = 1'b1;
					end
					if ((rd_next_w + 9'd1) > {1'b0, rd_tot_q}) begin
						res_d.done_res = 1'b1;
					end
				end
			end
			i2cs_pkg::KIND_ERROR: begin
				err_d = cmd.error_in;
				res_d.done_res = 1'b1;
				if (cmd.error_in != 7'd0) begin
					res_d.stop_req = 1'b1;
					res_d.failed   = 1'b1;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase

		res_d.ack_on     = ack_d;
		res_d.buf_irq_on = irq_d;
		res_d.rd_count   = rd_idx_d;
		res_d.error_bits = err_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_ptr_q <= '0;
			wr_idx_q <= '0;
			wr_tot_q <= '0;
			rd_idx_q <= '0;
			rd_tot_q <= '0;
			addr_q   <= '0;
			ack_q    <= 1'b0;
			irq_q    <= 1'b0;
			err_q    <= '0;
		end else if (in_fire) begin
			ld_ptr_q <= ld_ptr_d;
			wr_idx_q <= wr_idx_d;
			wr_tot_q <= wr_tot_d;
			rd_idx_q <= rd_idx_d;
			rd_tot_q <= rd_tot_d;
			addr_q   <= addr_d;
			ack_q    <= ack_d;
			irq_q    <= irq_d;
			err_q    <= err_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.dr_valid   = res_q.dr_valid;
	assign res.dr_value   = res_q.dr_value;
	assign res.start_req  = res_q.start_req;
	assign res.stop_req   = res_q.stop_req;
	assign res.ack_on     = res_q.ack_on;
	assign res.buf_irq_on = res_q.buf_irq_on;
	assign res.rd_valid   = res_q.rd_valid;
	assign res.rd_byte    = res_q.rd_byte;
	assign res.rd_count   = res_q.rd_count;
	assign res.done_res   = res_q.done_res;
	assign res.failed     = res_q.failed;
	assign res.error_bits = res_q.error_bits;

	// checks
	`ASSERT_ALWAYS(a_wr_idx_bound, clk, arst_n, wr_idx_q <= wr_tot_q,
		"write index past total")
	`ASSERT_ALWAYS(a_tot_bound, clk, arst_n,
		(wr_tot_q <= DEPTH_C) && (ld_ptr_q <= DEPTH_C), "buffer count past depth")
	`ASSERT_NEXT(a_start_clears, clk, arst_n,
		in_fire && (cmd.kind == i2cs_pkg::KIND_START),
		(rd_idx_q == 8'd0) && (wr_idx_q == '0) && irq_q, "start did not reset transfer")
	`ASSERT_IMPLY(a_fail_stops, clk, arst_n, out_valid_q && res_q.failed,
		res_q.stop_req && res_q.done_res, "failure without stop and done")

endmodule

`default_nettype wire

// ===== sv/i2cs_wbuf.sv =====
`default_nettype none

// Write buffer: one write port, one registered read port.
// A write to the address being read this cycle is forwarded, so rdata shows the
// new content of that address; a later write to it is not seen until it is read again.
module i2cs_wbuf #(
	parameter int WRITE_DEPTH = i2cs_pkg::WRITE_DEPTH_DEF,
	parameter int AW          = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [WRITE_DEPTH];
	logic [7:0] rdata_q;

	// storage write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read with write-first forwarding
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
